/* rtl/rpm_pkg.sv */
// Package for the response prefix matcher: codes, item and result types,
// register indexes and reset values. No dependencies.
package rpm_pkg;

    localparam int MAX_PATTERN_BYTES = 16;

    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 5;
    localparam int LEN_W      = 5;
    localparam int TIME_W     = 20;
    localparam int CNT_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int WORD_BYTES = 8;

    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 20'd1000;
    localparam logic [CNT_W-1:0]  LIMIT_RESET   = 9'd64;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_BYTE    = 2'd0,
        ST_MATCHED = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_MATCH   = 2'd1,
        PH_CAPTURE = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPTURE_MODE   = 3'd0,
        CFG_PATTERN_LOW    = 3'd1,
        CFG_PATTERN_HIGH   = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_TIMEOUT_MS     = 3'd4,
        CFG_CAPTURE_LIMIT  = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_result;

    typedef struct packed {
        logic              capture_mode;
        logic [LEN_W-1:0]  pattern_length;
        logic [TIME_W-1:0] timeout_ms;
        logic [CNT_W-1:0]  capture_limit;
    } t_cfg;

endpackage

/* rtl/rpm_cfg_regs.sv */
// Configuration register file of the response prefix matcher.
// Depends on rpm_pkg.
module rpm_cfg_regs
    import rpm_pkg::*;
#(
    parameter int P_MAX_BYTES = MAX_PATTERN_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  logic [CFG_IDX_W-1:0]        i_index,
    input  logic [CFG_DATA_W-1:0]       i_data,
    output t_cfg                        o_cfg,
    output logic [P_MAX_BYTES*BYTE_W-1:0] o_pattern
);

    t_cfg                          r_cfg, n_cfg;
    logic [P_MAX_BYTES*BYTE_W-1:0] r_pattern, n_pattern;

    always_comb begin
        n_cfg     = r_cfg;
        n_pattern = r_pattern;
        if (i_wr) begin
            unique case (i_index)
                CFG_CAPTURE_MODE:   n_cfg.capture_mode   = i_data[0];
                CFG_PATTERN_LENGTH: n_cfg.pattern_length = i_data[LEN_W-1:0];
                CFG_TIMEOUT_MS:     n_cfg.timeout_ms     = i_data[TIME_W-1:0];
                CFG_CAPTURE_LIMIT:  n_cfg.capture_limit  = i_data[CNT_W-1:0];
                CFG_PATTERN_LOW: begin
                    for (int k = 0; k < P_MAX_BYTES; k++) begin
                        if (k < WORD_BYTES)
                            n_pattern[k*BYTE_W +: BYTE_W] =
                                i_data[(k % WORD_BYTES)*BYTE_W +: BYTE_W];
                    end
                end
                CFG_PATTERN_HIGH: begin
                    for (int k = 0; k < P_MAX_BYTES; k++) begin
                        if (k >= WORD_BYTES)
                            n_pattern[k*BYTE_W +: BYTE_W] =
                                i_data[(k % WORD_BYTES)*BYTE_W +: BYTE_W];
                    end
                end
                default: ;  // unused indexes: drop the write
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capture_mode   <= 1'b0;
            r_cfg.pattern_length <= '0;
            r_cfg.timeout_ms     <= TIMEOUT_RESET;
            r_cfg.capture_limit  <= LIMIT_RESET;
            r_pattern            <= '0;
        end else begin
            r_cfg     <= n_cfg;
            r_pattern <= n_pattern;
        end
    end

    assign o_cfg     = r_cfg;
    assign o_pattern = r_pattern;

endmodule

/* rtl/rpm_engine.sv */
// Match and capture engine: phase, match index, timeout and capture count,
// updated once per advanced request. Depends on rpm_pkg.
module rpm_engine
    import rpm_pkg::*;
#(
    parameter int P_MAX_BYTES = MAX_PATTERN_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  t_item                         i_item,
    input  t_cfg                          i_cfg,
    input  logic [P_MAX_BYTES*BYTE_W-1:0] i_pattern,
    output logic                          o_res_valid,
    output t_result                       o_result
);

    localparam int PIDX_W = (P_MAX_BYTES > 1) ? $clog2(P_MAX_BYTES) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(P_MAX_BYTES);

    t_phase            r_phase, n_phase;
    logic [IDX_W-1:0]  r_idx, n_idx, w_idx_inc;
    logic [TIME_W-1:0] r_time, n_time, w_time_dec;
    logic [CNT_W-1:0]  r_count, n_count, w_count_inc;
    logic [LEN_W-1:0]  w_eff_len;
    logic [BYTE_W-1:0] w_pat_byte;
    logic              w_end;

    assign w_eff_len   = (i_cfg.pattern_length > MAX_LEN) ? MAX_LEN : i_cfg.pattern_length;
    assign w_pat_byte  = i_pattern[r_idx[PIDX_W-1:0]*BYTE_W +: BYTE_W];
    assign w_idx_inc   = r_idx + 1'b1;
    assign w_count_inc = r_count + 1'b1;
    assign w_time_dec  = (r_time != '0) ? r_time - 1'b1 : r_time;
    assign w_end       = (i_item.data == CHAR_CR) || (i_item.data == CHAR_LF) ||
                         (i_item.data == CHAR_NUL) || (w_count_inc >= i_cfg.capture_limit);

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_time      = r_time;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_result    = '{status: ST_BYTE, data: '0, last: 1'b0};
        unique case (i_item.op)
            OP_START: begin
                n_idx   = '0;
                n_count = '0;
                n_time  = i_cfg.timeout_ms;
                if (i_cfg.timeout_ms == '0) begin
                    n_phase         = PH_IDLE;
                    o_res_valid     = 1'b1;
                    o_result.status = ST_TIMEOUT;
                end else if (w_eff_len == '0) begin
                    if (i_cfg.capture_mode) begin
                        n_phase = PH_CAPTURE;
                    end else begin
                        n_phase         = PH_IDLE;
                        o_res_valid     = 1'b1;
                        o_result.status = ST_MATCHED;
                    end
                end else begin
                    n_phase = PH_MATCH;
                end
            end
            OP_BYTE: begin
                if (r_phase == PH_MATCH) begin
                    if (i_item.data == w_pat_byte) begin
                        n_idx = w_idx_inc;
                        if (w_idx_inc >= w_eff_len) begin
                            if (i_cfg.capture_mode) begin
                                n_phase = PH_CAPTURE;
                                n_count = '0;
                            end else begin
                                n_phase         = PH_IDLE;
                                o_res_valid     = 1'b1;
                                o_result.status = ST_MATCHED;
                            end
                        end
                    end else begin
                        n_idx = '0;
                    end
                end else if (r_phase == PH_CAPTURE) begin
                    n_count         = w_count_inc;
                    o_res_valid     = 1'b1;
                    o_result.status = ST_BYTE;
                    o_result.data   = i_item.data;
                    o_result.last   = w_end;
                    if (w_end)
                        n_phase = PH_IDLE;
                end
            end
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_time = w_time_dec;
                    if (w_time_dec == '0) begin
                        n_phase         = PH_IDLE;
                        o_res_valid     = 1'b1;
                        o_result.status = ST_TIMEOUT;
                    end
                end
            end
            default: ;  // unused code: no effect
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_time  <= '0;
            r_count <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_time  <= n_time;
            r_count <= n_count;
        end
    end

endmodule

/* rtl/rpm_out_reg.sv */
// Result register of the response prefix matcher with valid/ready output.
// Depends on rpm_pkg.
module rpm_out_reg
    import rpm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_can_take,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_can_take = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load)
            n_valid = 1'b1;
        else if (i_ready)
            n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= 1'b0;
        else
            r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_load)
            r_result <= i_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/response_prefix_matcher_core.sv */
// Top level of the response prefix matcher: input register, engine,
// result register and configuration registers. Depends on rpm_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | to core   | i_in_valid / o_in_ready   | i_operation, i_data_byte
//  out     | from core | o_out_valid / i_out_ready | o_status, o_captured_byte, o_last
//  cfg     | to core   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each request is held in the input register and evaluated by the engine straight from
// it when it advances; engine state and the result register (if the request gives a
// result) load as it advances. Throughput is one request per cycle, set by the single
// engine update, while the result register can take the result.
// Reset (i_rst_n low, synchronous) empties both registers, idles the engine
// and loads the register defaults. A held result stalls the input register
// only while the output side does not take it; cfg writes always complete.
module response_prefix_matcher_core
    import rpm_pkg::*;
#(
    parameter int P_MAX_PATTERN_BYTES = MAX_PATTERN_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [BYTE_W-1:0]     i_data_byte,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [BYTE_W-1:0]     o_captured_byte,
    output logic                  o_last,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                                  w_cfg;
    logic [P_MAX_PATTERN_BYTES*BYTE_W-1:0] w_pattern;

    logic    r_in_valid, n_in_valid;
    t_item   r_item;
    logic    w_advance;
    logic    w_out_can_take;
    logic    w_res_valid;
    t_result w_result;
    t_result w_out_result;

    // Configuration writes never stall.
    assign o_cfg_ready = 1'b1;

    rpm_cfg_regs #(
        .P_MAX_BYTES(P_MAX_PATTERN_BYTES)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_cfg_valid && o_cfg_ready),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_cfg    (w_cfg),
        .o_pattern(w_pattern)
    );

    // Advance the held request into the engine whenever the result register
    // can take whatever it produces; the input register refills in the same cycle.
    assign w_advance  = r_in_valid && w_out_can_take;
    assign o_in_ready = !r_in_valid || w_advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_in_valid && o_in_ready)
            n_in_valid = 1'b1;
        else if (w_advance)
            n_in_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_valid <= 1'b0;
        else
            r_in_valid <= n_in_valid;
    end

    // Hold the request payload until it advances.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready)
            r_item <= '{op: i_operation, data: i_data_byte};
    end

    rpm_engine #(
        .P_MAX_BYTES(P_MAX_PATTERN_BYTES)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_advance),
        .i_item     (r_item),
        .i_cfg      (w_cfg),
        .i_pattern  (w_pattern),
        .o_res_valid(w_res_valid),
        .o_result   (w_result)
    );

    // Capture a result only for requests that produce one.
    rpm_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_advance && w_res_valid),
        .i_result  (w_result),
        .i_ready   (i_out_ready),
        .o_can_take(w_out_can_take),
        .o_valid   (o_out_valid),
        .o_result  (w_out_result)
    );

    assign o_status        = w_out_result.status;
    assign o_captured_byte = w_out_result.data;
    assign o_last          = w_out_result.last;

endmodule

/* dv/tb_response_prefix_matcher_core.sv */
// Self-checking testbench for response_prefix_matcher_core: random request and result
// stalls, a request-by-request prediction of the matcher and a field-by-field result check.
// Depends on rpm_pkg and response_prefix_matcher_core.
`timescale 1ns / 1ps

module tb_response_prefix_matcher_core;
    import rpm_pkg::*;

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int RANDOM_REQUESTS = 700;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 200;

    // Code 3 on the operation field is not used by the block and must be dropped.
    localparam logic [OP_W-1:0]      OP_UNUSED        = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam logic [4*BYTE_W-1:0]  ALPHABET         = "ATOK";

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation = '0;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    logic [1:0]            o_status;
    logic [BYTE_W-1:0]     o_captured_byte;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    response_prefix_matcher_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_captured_byte (o_captured_byte),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Testbench copy of the registers and of the matcher state.
    logic                  reg_capture;
    logic [CFG_DATA_W-1:0] reg_pat_lo;
    logic [CFG_DATA_W-1:0] reg_pat_hi;
    logic [LEN_W-1:0]      reg_len;
    logic [TIME_W-1:0]     reg_timeout;
    logic [CNT_W-1:0]      reg_limit;
    t_phase                eng_phase;
    logic [IDX_W-1:0]      match_pos;
    logic [TIME_W-1:0]     ticks_left;
    logic [CNT_W-1:0]      line_count;

    t_item   pending_q[$];
    t_result expected_q[$];

    t_item   next_req;
    t_result resp;
    t_result want;
    bit      req_taken = 1'b0;
    bit      steady_flow = 1'b0;
    int      in_gap = 0;
    int      out_hold = 0;
    int      tick_pct = 0;
    int      noise_pct = 0;
    int      requests_queued = 0;
    int      requests_done = 0;
    int      results_seen = 0;
    int      line_bytes = 0;
    int      line_ends = 0;
    int      match_count = 0;
    int      timeouts = 0;
    int      writes_done = 0;
    int      errors = 0;
    int      cycle_count = 0;

    // Advance the matcher by one request; return 1 when it answers.
    function automatic bit predict_response(input logic [OP_W-1:0] op,
                                            input logic [BYTE_W-1:0] b,
                                            output t_result r);
        logic [LEN_W-1:0]        span;
        logic [2*CFG_DATA_W-1:0] pat;
        logic [BYTE_W-1:0]       wanted;
        logic                    line_end;
        span   = (reg_len > MAX_PATTERN_BYTES) ? LEN_W'(MAX_PATTERN_BYTES) : reg_len;
        pat    = {reg_pat_hi, reg_pat_lo};
        wanted = pat[match_pos[3:0]*BYTE_W +: BYTE_W];
        r = '{status: ST_BYTE, data: '0, last: 1'b0};
        case (op)
            OP_START: begin
                match_pos  = '0;
                line_count = '0;
                ticks_left = reg_timeout;
                // a zero timeout wins over an empty pattern
                if (ticks_left == '0) begin
                    eng_phase = PH_IDLE;
                    r.status  = ST_TIMEOUT;
                    return 1'b1;
                end
                if (span == '0) begin
                    if (reg_capture) begin
                        eng_phase = PH_CAPTURE;
                        return 1'b0;
                    end
                    eng_phase = PH_IDLE;
                    r.status  = ST_MATCHED;
                    return 1'b1;
                end
                eng_phase = PH_MATCH;
                return 1'b0;
            end
            OP_BYTE: begin
                if (eng_phase == PH_MATCH) begin
                    // naive restart: a failing byte is not compared again
                    if (b == wanted) begin
                        match_pos = match_pos + 1'b1;
                        if (match_pos >= span) begin
                            if (reg_capture) begin
                                eng_phase  = PH_CAPTURE;
                                line_count = '0;
                                return 1'b0;
                            end
                            eng_phase = PH_IDLE;
                            r.status  = ST_MATCHED;
                            return 1'b1;
                        end
                    end else begin
                        match_pos = '0;
                    end
                    return 1'b0;
                end
                if (eng_phase == PH_CAPTURE) begin
                    line_count = line_count + 1'b1;
                    line_end = (b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_NUL) ||
                               (line_count >= reg_limit);
                    if (line_end) eng_phase = PH_IDLE;
                    r.data = b;
                    r.last = line_end;
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_TICK: begin
                if (eng_phase != PH_IDLE) begin
                    if (ticks_left > '0) ticks_left = ticks_left - 1'b1;
                    if (ticks_left == '0) begin
                        eng_phase = PH_IDLE;
                        r.status  = ST_TIMEOUT;
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_CAPTURE_MODE:   reg_capture = val[0];
            CFG_PATTERN_LOW:    reg_pat_lo  = val;
            CFG_PATTERN_HIGH:   reg_pat_hi  = val;
            CFG_PATTERN_LENGTH: reg_len     = val[LEN_W-1:0];
            CFG_TIMEOUT_MS:     reg_timeout = val[TIME_W-1:0];
            CFG_CAPTURE_LIMIT:  reg_limit   = val[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // Queue one request; in the random part, sprinkle ticks and unused codes ahead of it.
    task automatic push_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
        if ($urandom_range(0, 99) < tick_pct) begin
            pending_q.push_back('{op: OP_TICK, data: BYTE_W'($urandom)});
            requests_queued++;
        end
        if ($urandom_range(0, 99) < noise_pct) begin
            pending_q.push_back('{op: OP_UNUSED, data: BYTE_W'($urandom)});
            requests_queued++;
        end
        pending_q.push_back('{op: op, data: b});
        requests_queued++;
    endtask

    // One search: start, some noise, maybe a broken prefix, the prefix, then a line.
    task automatic queue_exchange();
        int span;
        int k;
        int n;
        logic [2*CFG_DATA_W-1:0] pat;
        span = (reg_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(reg_len);
        pat  = {reg_pat_hi, reg_pat_lo};
        push_request(OP_START, BYTE_W'($urandom));
        repeat ($urandom_range(0, 3)) push_request(OP_BYTE, BYTE_W'($urandom));
        if (span > 1 && $urandom_range(0, 2) == 0) begin
            k = $urandom_range(1, span - 1);
            for (int i = 0; i < k; i++) push_request(OP_BYTE, pat[i*BYTE_W +: BYTE_W]);
            // flip one bit so the byte cannot match at this position
            push_request(OP_BYTE, pat[k*BYTE_W +: BYTE_W] ^ (8'h01 << $urandom_range(0, 7)));
        end
        for (int i = 0; i < span; i++) push_request(OP_BYTE, pat[i*BYTE_W +: BYTE_W]);
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) push_request(OP_BYTE, BYTE_W'($urandom));
            else push_request(OP_BYTE, BYTE_W'($urandom_range(8'h20, 8'h7e)));
        end
        case ($urandom_range(0, 3))
            0: push_request(OP_BYTE, CHAR_CR);
            1: push_request(OP_BYTE, CHAR_LF);
            2: push_request(OP_BYTE, CHAR_NUL);
            default: ;
        endcase
    endtask

    // Write one register and mirror it once the write is taken.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        load_register(idx, val);
        writes_done++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every request is taken and every answer is in, then let the pipe settle.
    task automatic drain_block();
        while (pending_q.size() != 0 || i_in_valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: hold a request until it is taken, then advance or idle.
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !req_taken)) begin
            if (in_gap > 0) begin
                i_in_valid <= 1'b0;
                in_gap--;
            end else if (pending_q.size() != 0) begin
                next_req = pending_q.pop_front();
                i_in_valid  <= 1'b1;
                i_operation <= next_req.op;
                i_data_byte <= next_req.data;
                in_gap = steady_flow ? 0 : ($urandom_range(0, 1) ? 0 : draw_gap());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure: stall in bursts unless the phase runs at full rate.
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_ready <= 1'b0;
            out_hold--;
        end else begin
            i_out_ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 3) == 0) out_hold = draw_gap();
        end
    end

    // Monitor: predict on each taken request, check each taken result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                requests_done++;
                if (predict_response(i_operation, i_data_byte, resp)) expected_q.push_back(resp);
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result, status %0d byte %02h last %0b",
                                 $time, o_status, o_captured_byte, o_last);
                end else begin
                    want = expected_q.pop_front();
                    if (o_status !== want.status) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: status expected %0d got %0d",
                                     $time, want.status, o_status);
                    end
                    if (o_captured_byte !== want.data) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: captured byte expected %02h got %02h",
                                     $time, want.data, o_captured_byte);
                    end
                    if (o_last !== want.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: last expected %0b got %0b",
                                     $time, want.last, o_last);
                    end
                    case (want.status)
                        ST_BYTE: begin
                            line_bytes++;
                            if (want.last) line_ends++;
                        end
                        ST_MATCHED: match_count++;
                        default:    timeouts++;
                    endcase
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int random_target;
        int phase_end;
        int phase_no;
        int r;
        logic                    cap;
        logic [2*CFG_DATA_W-1:0] pat;
        logic [LEN_W-1:0]        len;
        logic [TIME_W-1:0]       tmo;
        logic [CNT_W-1:0]        lim;

        // register defaults and idle engine, as after reset
        reg_capture = 1'b0;
        reg_pat_lo  = '0;
        reg_pat_hi  = '0;
        reg_len     = '0;
        reg_timeout = TIMEOUT_RESET;
        reg_limit   = LIMIT_RESET;
        eng_phase   = PH_IDLE;
        match_pos   = '0;
        ticks_left  = '0;
        line_count  = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: bytes, ticks and the unused code are dropped while idle;
        // an empty pattern in wait mode matches on start.
        push_request(OP_BYTE, 8'hFF);
        push_request(OP_TICK, 8'h00);
        push_request(OP_UNUSED, 8'h5A);
        push_request(OP_START, 8'hA5);
        drain_block();

        // Zero timeout times out on start, ahead of the empty pattern.
        write_register(CFG_TIMEOUT_MS, 64'd0);
        write_register(CFG_UNUSED_INDEX, '1);
        push_request(OP_START, 8'h00);
        drain_block();

        // Capture mode with empty pattern and zero limit: each line is one byte.
        write_register(CFG_CAPTURE_MODE, 64'd1);
        write_register(CFG_TIMEOUT_MS, 64'd3);
        write_register(CFG_CAPTURE_LIMIT, 64'd0);
        push_request(OP_START, 8'h00);
        push_request(OP_BYTE, 8'h41);
        push_request(OP_START, 8'h00);
        push_request(OP_BYTE, CHAR_CR);
        push_request(OP_START, 8'h00);
        push_request(OP_TICK, 8'hFF);
        push_request(OP_TICK, 8'h00);
        push_request(OP_TICK, 8'hFF);
        drain_block();

        // Two-byte prefix 00 FF: naive restart, then a restart by a second start.
        write_register(CFG_PATTERN_LOW, 64'h0000_0000_0000_FF00);
        write_register(CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(CFG_PATTERN_LENGTH, 64'd2);
        write_register(CFG_TIMEOUT_MS, 64'hF_FFFF);
        write_register(CFG_CAPTURE_LIMIT, 64'd256);
        push_request(OP_START, 8'h00);
        push_request(OP_BYTE, 8'h00);
        push_request(OP_BYTE, 8'h00);
        push_request(OP_BYTE, 8'h00);
        push_request(OP_BYTE, 8'hFF);
        push_request(OP_BYTE, 8'h80);
        push_request(OP_BYTE, CHAR_LF);
        push_request(OP_START, 8'h00);
        push_request(OP_BYTE, 8'h00);
        push_request(OP_START, 8'hFF);
        push_request(OP_BYTE, 8'h00);
        push_request(OP_BYTE, 8'hFF);
        push_request(OP_BYTE, CHAR_NUL);
        drain_block();

        // Random part: a new setting per phase, the first two at the extremes.
        noise_pct     = 2;
        phase_no      = 0;
        random_target = requests_queued + RANDOM_REQUESTS;
        while (requests_queued < random_target) begin
            if (phase_no == 0) begin
                cap = 1'b1; pat = '1; len = 5'd16; tmo = 20'hF_FFFF; lim = 9'd511;
            end else if (phase_no == 1) begin
                cap = 1'b0; pat = '0; len = 5'd31; tmo = 20'd1; lim = 9'd0;
            end else begin
                cap = 1'($urandom_range(0, 1));
                r = $urandom_range(0, 1);
                for (int i = 0; i < 2 * WORD_BYTES; i++)
                    pat[i*BYTE_W +: BYTE_W] = r ? ALPHABET[$urandom_range(0, 3)*BYTE_W +: BYTE_W]
                                                : BYTE_W'($urandom);
                r = $urandom_range(0, 19);
                if (r == 0)       len = '0;
                else if (r <= 12) len = LEN_W'($urandom_range(1, 6));
                else if (r <= 16) len = 5'd16;
                else if (r == 17) len = LEN_W'($urandom_range(7, 15));
                else              len = LEN_W'($urandom_range(17, 31));
                r = $urandom_range(0, 9);
                if (r == 0)      tmo = '0;
                else if (r <= 5) tmo = TIME_W'($urandom_range(1, 6));
                else if (r <= 8) tmo = TIME_W'($urandom_range(7, 200));
                else             tmo = 20'hF_FFFF;
                r = $urandom_range(0, 9);
                if (r == 0)      lim = '0;
                else if (r == 1) lim = 9'd511;
                else if (r == 2) lim = 9'd256;
                else             lim = CNT_W'($urandom_range(1, 12));
            end
            write_register(CFG_CAPTURE_MODE, CFG_DATA_W'(cap));
            write_register(CFG_PATTERN_LOW, pat[CFG_DATA_W-1:0]);
            write_register(CFG_PATTERN_HIGH, pat[2*CFG_DATA_W-1:CFG_DATA_W]);
            write_register(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
            write_register(CFG_TIMEOUT_MS, CFG_DATA_W'(tmo));
            write_register(CFG_CAPTURE_LIMIT, CFG_DATA_W'(lim));
            steady_flow = ($urandom_range(0, 3) == 0);
            tick_pct    = $urandom_range(0, 12);
            phase_end   = requests_queued + $urandom_range(30, 70);
            while (requests_queued < phase_end) queue_exchange();
            drain_block();
            phase_no++;
        end

        $display("Ran %0d requests over %0d register settings (%0d writes); %0d results.",
                 requests_done, phase_no + 4, writes_done, results_seen);
        $display("Saw %0d line bytes ending %0d lines, %0d prefix matches, %0d timeouts.",
                 line_bytes, line_ends, match_count, timeouts);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
